@@ sv/sptk_pkg.sv @@
// ----------------------------------------------------------------------------
// sptk_pkg
// Shared types and constants for the spectral peak top-K ranker.
// ----------------------------------------------------------------------------
package sptk_pkg;

    // field widths
    localparam int W_MAG = 32;
    localparam int W_BIN = 16;
    localparam int W_POS = 5;

    // default ranking depth
    localparam int RANK_DEPTH_DEF = 8;

    // history depth at which the peak test starts (window of three bins)
    localparam logic [1:0] HIST_FULL = 2'd2;

    // input item
    typedef struct packed {
        logic [W_MAG-1:0] magnitude;
        logic [W_BIN-1:0] bin_index;
        logic             frame_start;
        logic             frame_end;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [W_POS-1:0] rank_position;
        logic [W_MAG-1:0] peak_magnitude;
        logic [W_BIN-1:0] peak_bin;
        logic             entry_valid;
        logic             last_entry;
    } t_out_item;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic step;
        logic load;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic idx_last;
    } t_dp_stat;

endpackage

@@ sv/sptk_if.sv @@
// ----------------------------------------------------------------------------
// sptk_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface sptk_if #(
    parameter type T_PAYLOAD = logic
) ();
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/spectral_peak_top_k_ranker_top.sv @@
// ----------------------------------------------------------------------------
// spectral_peak_top_k_ranker_top
// Finds strict local maxima in a bin stream and keeps them ranked.
// ----------------------------------------------------------------------------
// Usage:
//   i_in takes one spectrum bin per item (magnitude, bin index, frame start
//   and frame end flags). Each bin is tested against its two neighbors and
//   a peak is inserted into a descending table of RANK_DEPTH entries by a
//   parallel compare-and-shift in the cycle the item is accepted.
//   Throughput: one item per cycle while no frame end is seen.
//   An item with frame end set produces RANK_DEPTH result items on o_out,
//   strongest first; the first is loaded into the output register once
//   the controller is in its emit state and that register is free, and
//   the rest follow one per cycle while the receiver takes them. While the
//   table is read out the input is held off until the last entry is loaded.
//   The next item is taken while the last result still waits in the output
//   register. A stalled receiver holds the readout at its current entry.
//   Reset (synchronous, active low) clears history and table to zero and
//   marks every entry invalid; frame start does the same for its bin.
// ----------------------------------------------------------------------------
module spectral_peak_top_k_ranker_top
    import sptk_pkg::*;
#(
    parameter int RANK_DEPTH = RANK_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sptk_if.sink   i_in,
    sptk_if.source o_out
);

    t_ctrl_cmd w_cmd;
    t_dp_stat  w_stat;
    t_in_item  w_in_item;
    t_out_item w_out_item;

    assign w_in_item = i_in.payload;

    // controller
    sptk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_frame_end (w_in_item.frame_end),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // datapath
    sptk_dp #(
        .RANK_DEPTH (RANK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_item      (w_in_item),
        .i_out_ready (o_out.ready),
        .o_stat      (w_stat),
        .o_item      (w_out_item),
        .o_valid     (o_out.valid)
    );

    assign i_in.ready    = w_cmd.in_ready;
    assign o_out.payload = w_out_item;

endmodule

@@ sv/sptk_ctrl.sv @@
// ----------------------------------------------------------------------------
// sptk_ctrl
// Controller: takes items while idle, then walks the table out one entry
// per free output slot after a frame end.
// ----------------------------------------------------------------------------
module sptk_ctrl
    import sptk_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_frame_end,
    input  t_dp_stat  i_stat,
    output t_ctrl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd.in_ready = 1'b0;
        o_cmd.step     = 1'b0;
        o_cmd.load     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.step = 1'b1;
                    if (i_frame_end) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.idx_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/sptk_dp.sv @@
// ----------------------------------------------------------------------------
// sptk_dp
// Datapath: bin history, peak test, compare-and-shift ranking table,
// read index and output register.
// ----------------------------------------------------------------------------
module sptk_dp
    import sptk_pkg::*;
#(
    parameter int RANK_DEPTH = RANK_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctrl_cmd i_cmd,
    input  t_in_item  i_item,
    input  logic      i_out_ready,
    output t_dp_stat  o_stat,
    output t_out_item o_item,
    output logic      o_valid
);

    localparam int W_IDX = $clog2(RANK_DEPTH);

    // history
    logic [W_MAG-1:0] r_older;
    logic [W_MAG-1:0] r_mid;
    logic [W_BIN-1:0] r_mid_bin;
    logic [1:0]       r_hist;
    logic [W_MAG-1:0] n_older;
    logic [1:0]       n_hist;

    // ranking table
    logic [W_MAG-1:0]      r_rmag [RANK_DEPTH];
    logic [W_BIN-1:0]      r_rbin [RANK_DEPTH];
    logic [RANK_DEPTH-1:0] r_rval;
    logic [W_MAG-1:0]      n_rmag [RANK_DEPTH];
    logic [W_BIN-1:0]      n_rbin [RANK_DEPTH];
    logic [RANK_DEPTH-1:0] n_rval;
    logic [RANK_DEPTH-1:0] w_gt;
    logic                  w_peak;

    // read side
    logic [W_IDX-1:0] r_idx;
    t_out_item        r_out;
    logic             r_out_valid;
    logic             w_idx_last;

    // peak test on the middle bin; a frame start discards the history
    always_comb begin
        w_peak = !i_item.frame_start && (r_hist == HIST_FULL) &&
                 (r_older < r_mid) && (i_item.magnitude < r_mid);
        if (i_item.frame_start) begin
            n_older = '0;
            n_hist  = 2'd1;
        end else begin
            n_older = r_mid;
            n_hist  = (r_hist == HIST_FULL) ? r_hist : r_hist + 2'd1;
        end
    end

    // one comparator per entry; the table is descending, so w_gt is a prefix
    always_comb begin
        for (int k = 0; k < RANK_DEPTH; k++) begin
            w_gt[k] = r_rmag[k] > r_mid;
        end
    end

    // new table contents: keep above the slot, insert at it, shift below; a frame start clears the table
    always_comb begin
        if (w_peak && !w_gt[0]) begin
            n_rmag[0] = r_mid;
            n_rbin[0] = r_mid_bin;
            n_rval[0] = 1'b1;
        end else begin
            n_rmag[0] = r_rmag[0];
            n_rbin[0] = r_rbin[0];
            n_rval[0] = r_rval[0];
        end
        for (int k = 1; k < RANK_DEPTH; k++) begin
            if (!w_peak || w_gt[k]) begin
                n_rmag[k] = r_rmag[k];
                n_rbin[k] = r_rbin[k];
                n_rval[k] = r_rval[k];
            end else if (w_gt[k-1]) begin
                n_rmag[k] = r_mid;
                n_rbin[k] = r_mid_bin;
                n_rval[k] = 1'b1;
            end else begin
                n_rmag[k] = r_rmag[k-1];
                n_rbin[k] = r_rbin[k-1];
                n_rval[k] = r_rval[k-1];
            end
        end
        if (i_item.frame_start) begin
            for (int k = 0; k < RANK_DEPTH; k++) begin
                n_rmag[k] = '0;
                n_rbin[k] = '0;
            end
            n_rval = '0;
        end
    end

    // history and table registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older   <= '0;
            r_mid     <= '0;
            r_mid_bin <= '0;
            r_hist    <= '0;
            r_rval    <= '0;
            for (int k = 0; k < RANK_DEPTH; k++) begin
                r_rmag[k] <= '0;
                r_rbin[k] <= '0;
            end
        end else if (i_cmd.step) begin
            r_older   <= n_older;
            r_mid     <= i_item.magnitude;
            r_mid_bin <= i_item.bin_index;
            r_hist    <= n_hist;
            r_rval    <= n_rval;
            for (int k = 0; k < RANK_DEPTH; k++) begin
                r_rmag[k] <= n_rmag[k];
                r_rbin[k] <= n_rbin[k];
            end
        end
    end

    assign w_idx_last = r_idx == W_IDX'(RANK_DEPTH - 1);

    // read index and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.step) begin
                r_idx <= '0;
            end else if (i_cmd.load) begin
                r_idx <= r_idx + W_IDX'(1);
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out <= '{rank_position:  W_POS'(r_idx),
                       peak_magnitude: r_rmag[r_idx],
                       peak_bin:       r_rbin[r_idx],
                       entry_valid:    r_rval[r_idx],
                       last_entry:     w_idx_last};
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_stat.idx_last = w_idx_last;
    assign o_item          = r_out;
    assign o_valid         = r_out_valid;

endmodule

@@ sv/sptk_chk.sv @@
// ----------------------------------------------------------------------------
// sptk_chk
// Port-level checks of the ranker's readout behavior, bound to the top.
// ----------------------------------------------------------------------------
module sptk_chk
    import sptk_pkg::*;
#(
    parameter int RANK_DEPTH = RANK_DEPTH_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_item
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // last flag marks the final position only
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_item.last_entry ==
            (i_out_item.rank_position == W_POS'(RANK_DEPTH - 1)))
        else $error("last flag on wrong position");

    // input is held off until the last entry is out
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_item.last_entry |-> !i_in_ready)
        else $error("input taken during readout");

    // readout continues at the next position with no larger magnitude
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_item.last_entry |=>
            i_out_valid &&
            i_out_item.rank_position ==
                W_POS'($past(i_out_item.rank_position) + W_POS'(1)) &&
            i_out_item.peak_magnitude <= $past(i_out_item.peak_magnitude))
        else $error("readout out of order");

endmodule

bind spectral_peak_top_k_ranker_top sptk_chk #(
    .RANK_DEPTH (RANK_DEPTH)
) u_sptk_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_item  (o_out.payload)
);

@@ sim/tb_spectral_peak_top_k_ranker_top.sv @@
// ----------------------------------------------------------------------------
// tb_spectral_peak_top_k_ranker_top
// Self-checking bench for the spectral peak top-K ranker.
// ----------------------------------------------------------------------------
// A behavioral ranking model follows every accepted bin: it keeps its own
// two-bin history and descending peak table, and queues the table readout
// for each frame end. Every result item from the block is compared field
// by field with the oldest queued entry. Stimulus opens with a handful of
// hand-built frames (extremes, plateaus, ties, start and end together)
// and then runs random frames with mostly well-formed flags, with random
// idle bursts on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_spectral_peak_top_k_ranker_top;
    import sptk_pkg::*;

    localparam int DEPTH     = RANK_DEPTH_DEF;
    localparam int N_RANDOM  = 125;
    localparam int QUIET_AT  = 100;
    localparam int HOLD_LEN  = 200;
    localparam int DRAIN_CYC = 2 * DEPTH + 8;

    // ------------------------------------------------------------------------
    // Ranking model and queue of expected table entries
    // ------------------------------------------------------------------------
    class peak_ranking_model;
        logic [W_MAG-1:0] older_mag;
        logic [W_MAG-1:0] mid_mag;
        logic [W_BIN-1:0] mid_bin;
        logic [1:0]       hist_cnt;
        logic [W_MAG-1:0] tab_mag [DEPTH];
        logic [W_BIN-1:0] tab_bin [DEPTH];
        logic             tab_vld [DEPTH];
        t_out_item        pending_entries [$];
        int               mismatch_count;

        function new();
            mismatch_count = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            older_mag = '0;
            mid_mag   = '0;
            mid_bin   = '0;
            hist_cnt  = '0;
            for (int k = 0; k < DEPTH; k++) begin
                tab_mag[k] = '0;
                tab_bin[k] = '0;
                tab_vld[k] = 1'b0;
            end
        endfunction

        // descending insert; ties go ahead of older equal entries
        function void insert_peak(logic [W_MAG-1:0] mag, logic [W_BIN-1:0] bin);
            int slot;
            int k;
            if (tab_mag[DEPTH-1] > mag) return;
            slot = 0;
            for (k = DEPTH - 2; k >= 0; k--) begin
                if (tab_mag[k] > mag) begin
                    slot = k + 1;
                    break;
                end
            end
            for (k = DEPTH - 1; k > slot; k--) begin
                tab_mag[k] = tab_mag[k-1];
                tab_bin[k] = tab_bin[k-1];
                tab_vld[k] = tab_vld[k-1];
            end
            tab_mag[slot] = mag;
            tab_bin[slot] = bin;
            tab_vld[slot] = 1'b1;
        endfunction

        // one accepted bin
        function void take_bin(t_in_item it);
            t_out_item e;
            if (it.frame_start) clear_frame();
            if (hist_cnt >= HIST_FULL) begin
                if (older_mag < mid_mag && it.magnitude < mid_mag)
                    insert_peak(mid_mag, mid_bin);
            end else begin
                hist_cnt = hist_cnt + 2'd1;
            end
            older_mag = mid_mag;
            mid_mag   = it.magnitude;
            mid_bin   = it.bin_index;
            if (it.frame_end) begin
                for (int k = 0; k < DEPTH; k++) begin
                    e.rank_position  = W_POS'(k);
                    e.peak_magnitude = tab_mag[k];
                    e.peak_bin       = tab_bin[k];
                    e.entry_valid    = tab_vld[k];
                    e.last_entry     = (k == DEPTH - 1);
                    // append at the tail
                    pending_entries = {pending_entries, e};
                end
            end
        endfunction

        // one accepted result item against the oldest expected entry
        function void check_entry(t_out_item got);
            t_out_item want;
            if (pending_entries.size() == 0) begin
                $error("unexpected result item: rank_position %0d", got.rank_position);
                mismatch_count++;
                return;
            end
            want = pending_entries.pop_front();
            if (got.rank_position !== want.rank_position) begin
                $error("rank_position: expected %0d, actual %0d",
                       want.rank_position, got.rank_position);
                mismatch_count++;
            end
            if (got.peak_magnitude !== want.peak_magnitude) begin
                $error("peak_magnitude: expected %0h, actual %0h",
                       want.peak_magnitude, got.peak_magnitude);
                mismatch_count++;
            end
            if (got.peak_bin !== want.peak_bin) begin
                $error("peak_bin: expected %0h, actual %0h", want.peak_bin, got.peak_bin);
                mismatch_count++;
            end
            if (got.entry_valid !== want.entry_valid) begin
                $error("entry_valid: expected %0b, actual %0b",
                       want.entry_valid, got.entry_valid);
                mismatch_count++;
            end
            if (got.last_entry !== want.last_entry) begin
                $error("last_entry: expected %0b, actual %0b",
                       want.last_entry, got.last_entry);
                mismatch_count++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels, block
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sptk_if #(.T_PAYLOAD(t_in_item))  bin_ch ();
    sptk_if #(.T_PAYLOAD(t_out_item)) rank_ch ();

    peak_ranking_model ranking = new();

    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;
    int bins_sent = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    spectral_peak_top_k_ranker_top #(
        .RANK_DEPTH (DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (bin_ch),
        .o_out   (rank_ch)
    );

    // ------------------------------------------------------------------------
    // Bin sender: called at a falling edge, returns at the falling edge
    // after the item was taken
    // ------------------------------------------------------------------------
    task automatic send_bin(input logic [W_MAG-1:0] mag, input logic [W_BIN-1:0] bin,
                            input logic fs, input logic fe);
        t_in_item it;
        it.magnitude   = mag;
        it.bin_index   = bin;
        it.frame_start = fs;
        it.frame_end   = fe;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            bin_ch.valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        bin_ch.valid   = 1'b1;
        bin_ch.payload = it;
        @(posedge i_clk);
        while (!bin_ch.ready) @(posedge i_clk);
        ranking.take_bin(it);
        bins_sent++;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Result receiver: ready bursts and the one long hold-off
    // ------------------------------------------------------------------------
    initial begin
        rank_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                rank_ch.ready = 1'b0;
                repeat (HOLD_LEN) @(negedge i_clk);
                rank_ch.ready = 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                rank_ch.ready = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
                rank_ch.ready = 1'b1;
            end else begin
                rank_ch.ready = 1'b1;
            end
        end
    end

    // check every accepted result item
    always @(posedge i_clk) begin
        if (i_rst_n && rank_ch.valid && rank_ch.ready)
            ranking.check_entry(rank_ch.payload);
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int frame_len;
        int mode;
        int start_from;
        logic [W_BIN-1:0] bin_base;
        logic [W_MAG-1:0] mag;
        logic fs;
        logic fe;

        bin_ch.valid   = 1'b0;
        bin_ch.payload = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // short history at frame start, extremes, plateau, tie with older peak
        send_bin(32'h0,        16'h0000, 1'b1, 1'b0);
        send_bin(32'hFFFFFFFF, 16'hFFFF, 1'b0, 1'b0);
        send_bin(32'h0,        16'h0001, 1'b0, 1'b0);
        send_bin(32'd5,        16'h0002, 1'b0, 1'b0);
        send_bin(32'd5,        16'h0003, 1'b0, 1'b0);
        send_bin(32'd3,        16'h0004, 1'b0, 1'b0);
        send_bin(32'd7,        16'h0005, 1'b0, 1'b0);
        send_bin(32'd1,        16'h0006, 1'b0, 1'b0);
        send_bin(32'd7,        16'h0007, 1'b0, 1'b0);
        send_bin(32'h0,        16'h0008, 1'b0, 1'b1);
        // table kept after frame end
        send_bin(32'h0,        16'h0009, 1'b0, 1'b1);
        // start and end on the same bin
        send_bin(32'h12345678, 16'hAAAA, 1'b1, 1'b1);
        // tiny frame with a single peak
        send_bin(32'd3,        16'h5555, 1'b1, 1'b0);
        send_bin(32'd9,        16'h5556, 1'b0, 1'b0);
        send_bin(32'd2,        16'h5557, 1'b0, 1'b1);

        // random frames; long receiver hold-off at the start of this part
        hold_req = 1'b1;
        start_from = bins_sent;
        while (bins_sent - start_from < N_RANDOM) begin
            frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2)
                                                    : $urandom_range(3, 30);
            mode      = $urandom_range(0, 9);
            bin_base  = W_BIN'($urandom);
            for (int i = 0; i < frame_len; i++) begin
                if (bins_sent - start_from >= QUIET_AT) idle_on = 1'b0;
                case (mode)
                    6, 7:    mag = $urandom;
                    8: begin
                        case ($urandom_range(0, 2))
                            0:       mag = 32'h0;
                            1:       mag = 32'hFFFFFFFF;
                            default: mag = 32'hFFFFFFFE;
                        endcase
                    end
                    9:       mag = 32'hFFFFFFF0 | W_MAG'($urandom_range(0, 15));
                    default: mag = W_MAG'($urandom_range(0, 15));
                endcase
                fs = (i == 0) && (mode != 5);
                fe = (i == frame_len - 1);
                // occasional broken flags
                if ($urandom_range(0, 24) == 0) fs = ~fs;
                if ($urandom_range(0, 24) == 0) fe = ~fe;
                send_bin(mag, (mode == 7) ? W_BIN'($urandom) : W_BIN'(bin_base + i), fs, fe);
            end
        end
        bin_ch.valid = 1'b0;

        // drain
        while (ranking.pending_entries.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (ranking.mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ spectral_peak_top_k_ranker_top.f @@
sv/sptk_pkg.sv
sv/sptk_if.sv
sv/sptk_ctrl.sv
sv/sptk_dp.sv
sv/spectral_peak_top_k_ranker_top.sv
sv/sptk_chk.sv
sim/tb_spectral_peak_top_k_ranker_top.sv
